>>> sv/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

>>> sv/utf8d_pkg.sv
package utf8d_pkg;

    localparam int CP_W = 21;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } byte_class_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            code_point_valid;
        logic            skipped_byte;
        logic            truncated;
        logic            text_end;
    } result_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  text_byte;
        logic        final_byte;
    } entry_t;

endpackage

>>> sv/utf8_code_point_decoder_top.sv
// Lenient streaming UTF-8 decoder: one byte per transaction on the item channel, one result
// per byte on the result channel, in order. Sustained rate is one byte per clock while the
// result channel is ready, set by the sequence state update in the back end; each result passes
// the classify register, a queue entry and the output register in that order before it is
// offered. Bytes following a lead are not checked; invalid leads are flagged as skipped, and a
// sequence open at the final byte is flagged as truncated. Every final byte returns the decoder
// to its lead-expecting state. QUEUE_DEPTH sets the entries between classifier and decoder
// (2 or more).
module utf8_code_point_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  utf8d_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output utf8d_pkg::result_t result
);
    import utf8d_pkg::*;

    logic   f_valid;
    logic   f_ready;
    entry_t f_ent;
    logic   q_valid;
    logic   q_ready;
    entry_t q_ent;

    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .ent_valid  (f_valid),
        .ent_ready  (f_ready),
        .ent        (f_ent)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_ent),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_ent)
    );

    utf8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ent_valid    (q_valid),
        .ent_ready    (q_ready),
        .ent          (q_ent),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> sv/utf8d_front.sv
module utf8d_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  utf8d_pkg::item_t item,
    output logic             ent_valid,
    input  logic             ent_ready,
    output utf8d_pkg::entry_t ent
);
    import utf8d_pkg::*;

    logic        valid_reg;
    entry_t      ent_reg;
    entry_t      ent_next;
    byte_class_t cls;

    always_comb
    begin
        case (item.text_byte) inside
            [8'h00:8'h7F]: cls = CLS_ASCII;
            [8'hC0:8'hDF]: cls = CLS_LEAD2;
            [8'hE0:8'hEF]: cls = CLS_LEAD3;
            [8'hF0:8'hF7]: cls = CLS_LEAD4;
            default:       cls = CLS_INVALID;
        endcase
        ent_next.cls        = cls;
        ent_next.text_byte  = item.text_byte;
        ent_next.final_byte = item.final_byte;
    end

    assign item_ready = !valid_reg || ent_ready;
    assign ent_valid  = valid_reg;
    assign ent        = ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

>>> sv/utf8d_queue.sv
`include "assert_macros.svh"

module utf8d_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  utf8d_pkg::entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output utf8d_pkg::entry_t pop_data
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = count_reg < CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `ASSERT_NEXT(a_pop_drains, pop && !push && count_reg == CNT_W'(1), !pop_valid, "queue not empty after last pop")

endmodule

>>> sv/utf8d_back.sv
`include "assert_macros.svh"

module utf8d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ent_valid,
    output logic               ent_ready,
    input  utf8d_pkg::entry_t  ent,
    output logic               result_valid,
    input  logic               result_ready,
    output utf8d_pkg::result_t result
);
    import utf8d_pkg::*;

    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [1:0]      remain_reg;
    logic [1:0]      remain_next;
    logic [1:0]      remain_dec;
    logic [CP_W-1:0] shifted;
    logic            out_valid_reg;
    result_t         out_reg;
    result_t         out_next;
    logic            take;

    assign ent_ready    = !out_valid_reg || result_ready;
    assign take         = ent_valid && ent_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign shifted      = {partial_reg[CP_W-7:0], ent.text_byte[5:0]};
    assign remain_dec   = remain_reg - 2'd1;

    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        out_next     = '0;
        if (remain_reg == 2'd0)
        begin
            case (ent.cls)
                CLS_ASCII:
                begin
                    out_next.code_point       = CP_W'(ent.text_byte[6:0]);
                    out_next.code_point_valid = 1'b1;
                end
                CLS_LEAD2:
                begin
                    partial_next = CP_W'(ent.text_byte[4:0]);
                    remain_next  = 2'd1;
                end
                CLS_LEAD3:
                begin
                    partial_next = CP_W'(ent.text_byte[3:0]);
                    remain_next  = 2'd2;
                end
                CLS_LEAD4:
                begin
                    partial_next = CP_W'(ent.text_byte[2:0]);
                    remain_next  = 2'd3;
                end
                default:
                begin
                    out_next.skipped_byte = 1'b1;
                end
            endcase
        end
        else
        begin
            remain_next = remain_dec;
            if (remain_dec == 2'd0)
            begin
                out_next.code_point       = shifted;
                out_next.code_point_valid = 1'b1;
                partial_next              = '0;
            end
            else
            begin
                partial_next = shifted;
            end
        end
        if (ent.final_byte)
        begin
            out_next.truncated = remain_next != 2'd0;
            partial_next       = '0;
            remain_next        = 2'd0;
        end
        out_next.text_end = ent.final_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remain_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                partial_reg <= partial_next;
                remain_reg  <= remain_next;
            end
            if (ent_ready)
            begin
                out_valid_reg <= ent_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    // end of text always leaves the decoder expecting a lead
    `ASSERT_NEXT(a_final_clears, take && ent.final_byte, remain_reg == 2'd0 && partial_reg == '0, "state not cleared after final byte")
    `ASSERT_IMPLIES(a_trunc_at_end, out_valid_reg && out_reg.truncated, out_reg.text_end, "truncation flagged away from text end")
    `ASSERT_IMPLIES(a_one_outcome, out_valid_reg, !(out_reg.code_point_valid && (out_reg.skipped_byte || out_reg.truncated)), "conflicting result flags")

endmodule

>>> tb/utf8_decode_checker.sv
`timescale 1ns / 1ps

module utf8_decode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  utf8d_pkg::item_t   item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  utf8d_pkg::result_t result,
    output int                 errors,
    output int                 pending
);
    import utf8d_pkg::*;

    logic [CP_W-1:0] seq_value;
    logic [1:0]      seq_left;
    result_t         expected_q[$];

    function automatic byte_class_t classify(input logic [7:0] b);
        if (b[7] == 1'b0)
            return CLS_ASCII;
        if (b[7:5] == 3'b110)
            return CLS_LEAD2;
        if (b[7:4] == 4'b1110)
            return CLS_LEAD3;
        if (b[7:3] == 5'b11110)
            return CLS_LEAD4;
        return CLS_INVALID;
    endfunction

    // advances the sequence state by one byte
    function automatic result_t decode_byte(input item_t it);
        result_t r;
        r = '0;
        r.text_end = it.final_byte;
        if (seq_left == 2'd0)
        begin
            case (classify(it.text_byte))
                CLS_ASCII:
                begin
                    r.code_point       = CP_W'(it.text_byte);
                    r.code_point_valid = 1'b1;
                end
                CLS_LEAD2:
                begin
                    seq_value = CP_W'(it.text_byte[4:0]);
                    seq_left  = 2'd1;
                end
                CLS_LEAD3:
                begin
                    seq_value = CP_W'(it.text_byte[3:0]);
                    seq_left  = 2'd2;
                end
                CLS_LEAD4:
                begin
                    seq_value = CP_W'(it.text_byte[2:0]);
                    seq_left  = 2'd3;
                end
                default:
                    r.skipped_byte = 1'b1;
            endcase
        end
        else
        begin
            seq_value = {seq_value[CP_W-7:0], it.text_byte[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                r.code_point       = seq_value;
                r.code_point_valid = 1'b1;
                seq_value          = '0;
            end
        end
        if (it.final_byte)
        begin
            r.truncated = (seq_left != 2'd0);
            seq_value   = '0;
            seq_left    = 2'd0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            seq_value = '0;
            seq_left  = 2'd0;
            expected_q.delete();
        end
        else
        begin
            if (item_valid && item_ready)
                expected_q = {expected_q, decode_byte(item)};
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, actual 0x%0h",
                             $time, result);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("code_point", want.code_point, result.code_point);
                    check_field("code_point_valid", want.code_point_valid,
                                result.code_point_valid);
                    check_field("skipped_byte", want.skipped_byte, result.skipped_byte);
                    check_field("truncated", want.truncated, result.truncated);
                    check_field("text_end", want.text_end, result.text_end);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import utf8d_pkg::*;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    int      errors;
    int      pending;
    bit      steady       = 1'b0;
    int      sent         = 0;
    int      n_text       = 0;

    logic [8:0] directed[] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},
        {8'hC2, 1'b0}, {8'hA9, 1'b0},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
        {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0},
        {8'h80, 1'b0}, {8'hF8, 1'b0}, {8'hFF, 1'b1},
        {8'hC3, 1'b0}, {8'h41, 1'b0},
        {8'hE0, 1'b0}, {8'hFF, 1'b0}, {8'hC0, 1'b0},
        {8'hC3, 1'b1},
        {8'hE2, 1'b0}, {8'h82, 1'b1},
        {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1}
    };

    always #1 clk = ~clk;

    utf8_code_point_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    utf8_decode_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= 34);

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(99) < 34)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{text_byte: b, final_byte: fin};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [7:0] lead_byte(input int unsigned len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] follow_byte();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    // mostly well-formed sequences, some noise; a cut text ends inside a sequence
    task automatic send_text(input int unsigned n_units, input bit cut);
        logic [7:0]  bytes[$];
        int unsigned kind;
        int unsigned len;
        for (int u = 0; u < n_units; u++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                bytes = {bytes, {1'b0, 7'($urandom)}};
            else if (kind < 84)
            begin
                len = (kind < 60) ? 2 : (kind < 72) ? 3 : 4;
                bytes = {bytes, lead_byte(len)};
                for (int k = 1; k < len; k++)
                    bytes = {bytes, follow_byte()};
            end
            else if (kind < 92)
                bytes = {bytes, {2'b10, 6'($urandom)}};
            else
                bytes = {bytes, 8'($urandom)};
        end
        if (cut)
        begin
            len = $urandom_range(2, 4);
            bytes = {bytes, lead_byte(len)};
            for (int k = $urandom_range(len - 2); k > 0; k--)
                bytes = {bytes, follow_byte()};
        end
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_byte(directed[i][8:1], directed[i][0]);
        while (sent < 700)
        begin
            n_text++;
            steady = (n_text >= 20 && n_text < 45);
            if (n_text == 60)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
            end
            send_text($urandom_range(1, 12), $urandom_range(99) < 15);
        end
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[utf8_code_point_decoder_top] OK");
        else
            $display("[utf8_code_point_decoder_top] ERROR");
        $finish;
    end

    initial
    begin
        #200000;
        $display("[utf8_code_point_decoder_top] ERROR");
        $finish;
    end

endmodule
